/* hdl/qpn_pkg.sv */
// ----------------------------------------------------------------------------
// qpn_pkg
// Shared constants for the normalized quaternion product unit.
// ----------------------------------------------------------------------------
package qpn_pkg;

  // Default component width: Q2.14 signed fixed point.
  localparam int COMPONENT_WIDTH_DEF = 16;

  // Number of quaternion components handled side by side.
  localparam int LANES = 4;

  // Component positions within a quaternion.
  localparam int IDX_X = 0;
  localparam int IDX_Y = 1;
  localparam int IDX_Z = 2;
  localparam int IDX_W = 3;

endpackage

/* hdl/qpn_channels.sv */
// ----------------------------------------------------------------------------
// qpn channel interfaces
// Valid/ready channels for operand pairs and normalized results.
// ----------------------------------------------------------------------------
interface qpn_operand_if #(
  parameter int W = qpn_pkg::COMPONENT_WIDTH_DEF
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] first_x;
  logic signed [W-1:0] first_y;
  logic signed [W-1:0] first_z;
  logic signed [W-1:0] first_w;
  logic signed [W-1:0] second_x;
  logic signed [W-1:0] second_y;
  logic signed [W-1:0] second_z;
  logic signed [W-1:0] second_w;

  modport source (
    output valid, first_x, first_y, first_z, first_w,
    output second_x, second_y, second_z, second_w,
    input  ready
  );
  modport sink (
    input  valid, first_x, first_y, first_z, first_w,
    input  second_x, second_y, second_z, second_w,
    output ready
  );
endinterface

interface qpn_result_if #(
  parameter int W = qpn_pkg::COMPONENT_WIDTH_DEF
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] out_x;
  logic signed [W-1:0] out_y;
  logic signed [W-1:0] out_z;
  logic signed [W-1:0] out_w;
  logic                zero_norm;

  modport source (
    output valid, out_x, out_y, out_z, out_w, zero_norm,
    input  ready
  );
  modport sink (
    input  valid, out_x, out_y, out_z, out_w, zero_norm,
    output ready
  );
endinterface

/* hdl/qpn_root_step.sv */
// ----------------------------------------------------------------------------
// qpn_root_step
// One bit of the restoring ratio search: decides bit J of the scaled
// ratio u = floor(2*|p|*2^F / sqrt(n)) by testing (u + 2^J)^2 * n
// against the remaining budget.
// ----------------------------------------------------------------------------
module qpn_root_step #(
  parameter int RW = 100,
  parameter int UW = 16,
  parameter int J  = 0
) (
  input  logic [RW-1:0] rem,
  input  logic [RW-1:0] acc,
  input  logic [UW-1:0] root,
  input  logic [RW-1:0] norm,
  output logic [RW-1:0] rem_next,
  output logic [RW-1:0] acc_next,
  output logic [UW-1:0] root_next
);

  logic [RW-1:0] sub;
  logic [RW:0]   diff;

  // Growth of u^2*n when bit J is set: 2^(J+1)*u*n + 2^(2J)*n.
  always_comb begin
    sub  = (acc << (J + 1)) + (norm << (2 * J));
    diff = {1'b0, rem} - {1'b0, sub};
    if (!diff[RW]) begin
      rem_next  = diff[RW-1:0];
      acc_next  = acc + (norm << J);
      root_next = root | (UW'(1) << J);
    end else begin
      rem_next  = rem;
      acc_next  = acc;
      root_next = root;
    end
  end

endmodule

/* hdl/quaternion_product_normalized_unit.sv */
// ----------------------------------------------------------------------------
// quaternion_product_normalized_unit
// Hamilton product of two Q2.F quaternions, scaled to unit length and
// rounded to nearest (ties away from zero), with a flag for a zero product.
// ----------------------------------------------------------------------------
// Pipeline from operand beat to result beat: five arithmetic stages, one
//   stage per result bit of the ratio search, and the output register.
// Throughput: one beat per cycle while the result side is ready; each stage
//   advances on its own, so bubbles close up behind a stalled result.
// Reset clears the stage valid bits only; data registers are not reset.
module quaternion_product_normalized_unit #(
  parameter int COMPONENT_WIDTH = qpn_pkg::COMPONENT_WIDTH_DEF
) (
  input logic         clk,
  input logic         rst,
  qpn_operand_if.sink operands,
  qpn_result_if.source result
);
  import qpn_pkg::*;

  localparam int W     = COMPONENT_WIDTH;
  localparam int F     = W - 2;
  localparam int PRW   = 2 * W;        // one component product
  localparam int PW    = 2 * W + 2;    // product quaternion component
  localparam int MW    = 2 * W + 1;    // its magnitude
  localparam int ML    = W;            // low part of the magnitude split
  localparam int MH    = MW - ML;      // high part
  localparam int SQW   = 4 * W + 2;    // square of a magnitude
  localparam int NW    = SQW + 2;      // sum of four squares
  localparam int RW    = 6 * W + 4;    // search budget and terms
  localparam int NSTEP = W;            // ratio bits F+1 down to 0
  localparam int UW    = W;
  localparam int NS    = NSTEP + 6;
  localparam int LAST  = NS - 1;
  localparam int SE    = 4;            // stage that starts the search
  localparam int UNIT  = 1 << F;

  // Stage handshake: a stage loads when it is empty or its successor loads.
  logic [NS-1:0] v;
  logic [NS-1:0] en;

  always_comb begin
    en[LAST] = !v[LAST] || result.ready;
    for (int i = LAST - 1; i >= 0; i--) begin
      en[i] = !v[i] || en[i+1];
    end
  end

  assign operands.ready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= operands.valid;
      end
      for (int i = 1; i < NS; i++) begin
        if (en[i]) begin
          v[i] <= v[i-1];
        end
      end
    end
  end

  // Stage A: the sixteen component products a_i * b_j.
  logic signed [W-1:0]   qa [LANES];
  logic signed [W-1:0]   qb [LANES];
  logic signed [PRW-1:0] prod [LANES*LANES];

  always_comb begin
    qa[IDX_X] = operands.first_x;
    qa[IDX_Y] = operands.first_y;
    qa[IDX_Z] = operands.first_z;
    qa[IDX_W] = operands.first_w;
    qb[IDX_X] = operands.second_x;
    qb[IDX_Y] = operands.second_y;
    qb[IDX_Z] = operands.second_z;
    qb[IDX_W] = operands.second_w;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int i = 0; i < LANES; i++) begin
        for (int j = 0; j < LANES; j++) begin
          prod[i*LANES+j] <= PRW'(qa[i]) * PRW'(qb[j]);
        end
      end
    end
  end

  // Stage B: Hamilton product, exact.
  logic signed [PW-1:0] pe [LANES*LANES];
  logic signed [PW-1:0] pq [LANES];

  always_comb begin
    for (int i = 0; i < LANES * LANES; i++) begin
      pe[i] = PW'(prod[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      pq[IDX_X] <= pe[IDX_W*LANES+IDX_X] + pe[IDX_X*LANES+IDX_W]
                 + pe[IDX_Y*LANES+IDX_Z] - pe[IDX_Z*LANES+IDX_Y];
      pq[IDX_Y] <= pe[IDX_W*LANES+IDX_Y] + pe[IDX_Y*LANES+IDX_W]
                 + pe[IDX_Z*LANES+IDX_X] - pe[IDX_X*LANES+IDX_Z];
      pq[IDX_Z] <= pe[IDX_W*LANES+IDX_Z] + pe[IDX_Z*LANES+IDX_W]
                 + pe[IDX_X*LANES+IDX_Y] - pe[IDX_Y*LANES+IDX_X];
      pq[IDX_W] <= pe[IDX_W*LANES+IDX_W] - pe[IDX_X*LANES+IDX_X]
                 - pe[IDX_Y*LANES+IDX_Y] - pe[IDX_Z*LANES+IDX_Z];
    end
  end

  // Stage C: sign, magnitude and the partial products of its square.
  logic [PW-1:0]      pneg [LANES];
  logic [MW-1:0]      mag [LANES];
  logic [LANES-1:0]   neg_c;
  logic [2*MH-1:0]    pp_hh [LANES];
  logic [MH+ML-1:0]   pp_hl [LANES];
  logic [2*ML-1:0]    pp_ll [LANES];

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      pneg[l] = -pq[l];
      mag[l]  = pq[l][PW-1] ? pneg[l][MW-1:0] : pq[l][MW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int l = 0; l < LANES; l++) begin
        neg_c[l] <= pq[l][PW-1];
        pp_hh[l] <= (2*MH)'(mag[l][MW-1:ML]) * (2*MH)'(mag[l][MW-1:ML]);
        pp_hl[l] <= (MH+ML)'(mag[l][MW-1:ML]) * (MH+ML)'(mag[l][ML-1:0]);
        pp_ll[l] <= (2*ML)'(mag[l][ML-1:0]) * (2*ML)'(mag[l][ML-1:0]);
      end
    end
  end

  // Stage D: squares of the magnitudes.
  logic [SQW-1:0]   sq [LANES];
  logic [LANES-1:0] neg_d;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      neg_d <= neg_c;
      for (int l = 0; l < LANES; l++) begin
        sq[l] <= (SQW'(pp_hh[l]) << (2 * ML)) + (SQW'(pp_hl[l]) << (ML + 1))
               + SQW'(pp_ll[l]);
      end
    end
  end

  // Search registers, index 0 loaded by stage E, then one per bit.
  logic [RW-1:0]    rem_q  [NSTEP+1][LANES];
  logic [RW-1:0]    acc_q  [NSTEP+1][LANES];
  logic [UW-1:0]    root_q [NSTEP+1][LANES];
  logic [RW-1:0]    norm_q [NSTEP+1];
  logic [LANES-1:0] neg_q  [NSTEP+1];
  logic             zero_q [NSTEP+1];
  logic [NW-1:0]    nsum;

  // Stage E: squared length, zero test and the initial budgets.
  assign nsum = NW'(sq[IDX_X]) + NW'(sq[IDX_Y]) + NW'(sq[IDX_Z]) + NW'(sq[IDX_W]);

  always_ff @(posedge clk) begin
    if (en[SE]) begin
      norm_q[0] <= RW'(nsum);
      zero_q[0] <= (nsum == '0);
      neg_q[0]  <= neg_d;
      for (int l = 0; l < LANES; l++) begin
        rem_q[0][l]  <= RW'(sq[l]) << (2 * F + 2);
        acc_q[0][l]  <= '0;
        root_q[0][l] <= '0;
      end
    end
  end

  // Search stages: one ratio bit per stage for all four lanes.
  for (genvar q = 1; q <= NSTEP; q++) begin : g_step
    logic [RW-1:0] rem_n  [LANES];
    logic [RW-1:0] acc_n  [LANES];
    logic [UW-1:0] root_n [LANES];

    for (genvar l = 0; l < LANES; l++) begin : g_lane
      qpn_root_step #(
        .RW (RW),
        .UW (UW),
        .J  (NSTEP - q)
      ) u_step (
        .rem       (rem_q[q-1][l]),
        .acc       (acc_q[q-1][l]),
        .root      (root_q[q-1][l]),
        .norm      (norm_q[q-1]),
        .rem_next  (rem_n[l]),
        .acc_next  (acc_n[l]),
        .root_next (root_n[l])
      );
    end

    always_ff @(posedge clk) begin
      if (en[SE+q]) begin
        norm_q[q] <= norm_q[q-1];
        zero_q[q] <= zero_q[q-1];
        neg_q[q]  <= neg_q[q-1];
        for (int l = 0; l < LANES; l++) begin
          rem_q[q][l]  <= rem_n[l];
          acc_q[q][l]  <= acc_n[l];
          root_q[q][l] <= root_n[l];
        end
      end
    end
  end

  // Output stage: round the doubled ratio to nearest and apply the sign.
  // With a zero length the search sets every bit, so the components are
  // forced to zero here.
  logic [UW:0]         ksum [LANES];
  logic [W-1:0]        kmag [LANES];
  logic signed [W-1:0] oval [LANES];
  logic                zero_o;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      ksum[l] = {1'b0, root_q[NSTEP][l]} + (UW+1)'(1);
      kmag[l] = ksum[l][UW:1];
    end
  end

  always_ff @(posedge clk) begin
    if (en[LAST]) begin
      zero_o <= zero_q[NSTEP];
      for (int l = 0; l < LANES; l++) begin
        if (zero_q[NSTEP]) begin
          oval[l] <= '0;
        end else begin
          oval[l] <= neg_q[NSTEP][l] ? -kmag[l] : kmag[l];
        end
      end
    end
  end

  assign result.valid     = v[LAST];
  assign result.out_x     = oval[IDX_X];
  assign result.out_y     = oval[IDX_Y];
  assign result.out_z     = oval[IDX_Z];
  assign result.out_w     = oval[IDX_W];
  assign result.zero_norm = zero_o;

  // A zero product gives all-zero components.
  a_zero_outputs: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.zero_norm |->
      result.out_x == '0 && result.out_y == '0 &&
      result.out_z == '0 && result.out_w == '0)
    else $error("zero product with nonzero components");

  // The x and w components of a unit quaternion stay within plus or minus one.
  a_unit_range: assert property (@(posedge clk) disable iff (rst)
    result.valid |->
      int'(result.out_x) <= UNIT && int'(result.out_x) >= -UNIT &&
      int'(result.out_w) <= UNIT && int'(result.out_w) >= -UNIT)
    else $error("normalized component out of range");

  // A stalled search stage keeps its beat.
  a_search_hold: assert property (@(posedge clk) disable iff (rst)
    v[SE] && !en[SE] |=> v[SE])
    else $error("search stage dropped a beat while stalled");

  // A beat moves into the output register only when the last search stage held one.
  a_output_source: assert property (@(posedge clk) disable iff (rst)
    en[LAST] && !v[LAST-1] |=> !v[LAST])
    else $error("result appeared without a source beat");

endmodule

/* test/tb_quaternion_product_normalized_unit.sv */
// ----------------------------------------------------------------------------
// tb_quaternion_product_normalized_unit
// Sends quaternion pairs through the operand channel and checks every result
// beat, field by field, against an exact integer model of the normalized
// Hamilton product, with random idle bursts on both channels.
// ----------------------------------------------------------------------------
module tb_quaternion_product_normalized_unit;

  localparam int W = qpn_pkg::COMPONENT_WIDTH_DEF;
  localparam int F = W - 2;
  localparam int IDLE_LIMIT = 3000;
  localparam int RANDOM_PAIRS = 550;
  localparam int QUIET_TAIL = 60;

  typedef struct packed {
    logic signed [W-1:0] ax, ay, az, aw, bx, by, bz, bw;
  } qpair_t;

  typedef struct packed {
    logic signed [W-1:0] x, y, z, w;
    logic                zero;
  } unit_q_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  qpn_operand_if #(.W(W)) op_ch ();
  qpn_result_if  #(.W(W)) res_ch ();

  quaternion_product_normalized_unit #(.COMPONENT_WIDTH(W)) DUT (
    .clk      (clk),
    .rst      (rst),
    .operands (op_ch),
    .result   (res_ch)
  );

  qpair_t  pair_queue[$];
  unit_q_t unit_expected[$];
  int      errors = 0;
  bit      op_taken = 1'b0;
  int      send_gap = 0;
  int      stall_gap = 0;
  int      idle_odds = 4;
  int      idle_cycles = 0;
  bit      stim_done = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Signed product of two components at full width.
  function automatic longint cmul(logic signed [W-1:0] a, logic signed [W-1:0] b);
    return longint'(a) * longint'(b);
  endfunction

  // Largest k with (2k-1)^2 * n <= psq * 2^(2F+2): round(|p| * 2^F / sqrt(n)).
  function automatic int unit_ratio(logic [127:0] psq, logic [127:0] n);
    longint lo, hi, mid, t;
    logic [127:0] lhs, rhs;
    lo = 0;
    hi = longint'(1) << F;
    rhs = psq << (2 * F + 2);
    while (lo < hi) begin
      mid = lo + (hi - lo + 1) / 2;
      t = 2 * mid - 1;
      lhs = 128'(t * t) * n;
      if (lhs <= rhs) lo = mid;
      else hi = mid - 1;
    end
    return int'(lo);
  endfunction

  // Exact Hamilton product, scaled to unit length.
  function automatic unit_q_t hamilton_unit(qpair_t q);
    longint p[4];
    logic [127:0] sq[4];
    logic [127:0] n;
    logic [63:0] m;
    logic signed [W-1:0] c[4];
    int k;
    unit_q_t r;
    p[0] = cmul(q.aw, q.bx) + cmul(q.ax, q.bw) + cmul(q.ay, q.bz) - cmul(q.az, q.by);
    p[1] = cmul(q.aw, q.by) + cmul(q.ay, q.bw) + cmul(q.az, q.bx) - cmul(q.ax, q.bz);
    p[2] = cmul(q.aw, q.bz) + cmul(q.az, q.bw) + cmul(q.ax, q.by) - cmul(q.ay, q.bx);
    p[3] = cmul(q.aw, q.bw) - cmul(q.ax, q.bx) - cmul(q.ay, q.by) - cmul(q.az, q.bz);
    n = '0;
    for (int i = 0; i < 4; i++) begin
      m = (p[i] < 0) ? 64'(-p[i]) : 64'(p[i]);
      sq[i] = {64'd0, m} * {64'd0, m};
      n = n + sq[i];
    end
    for (int i = 0; i < 4; i++) begin
      c[i] = '0;
      if (n != 0) begin
        k = unit_ratio(sq[i], n);
        c[i] = (p[i] < 0) ? W'(-k) : W'(k);
      end
    end
    r.x = c[qpn_pkg::IDX_X];
    r.y = c[qpn_pkg::IDX_Y];
    r.z = c[qpn_pkg::IDX_Z];
    r.w = c[qpn_pkg::IDX_W];
    r.zero = (n == 0);
    return r;
  endfunction

  function automatic logic signed [W-1:0] rand_component(int style);
    case (style)
      0: return W'($urandom);
      1: return W'($urandom_range(0, 64)) - W'(32);
      2: return $urandom_range(0, 1) ? {1'b0, {(W-1){1'b1}}} : {1'b1, {(W-1){1'b0}}};
      3: return '0;
      default: return $urandom_range(0, 1) ? W'(1 << F) : -W'(1 << F);
    endcase
  endfunction

  function automatic qpair_t rand_pair();
    qpair_t q;
    int mode;
    mode = $urandom_range(0, 9);
    q.ax = rand_component(mode < 6 ? 0 : $urandom_range(0, 4));
    q.ay = rand_component(mode < 6 ? 0 : $urandom_range(0, 4));
    q.az = rand_component(mode < 6 ? 0 : $urandom_range(0, 4));
    q.aw = rand_component(mode < 6 ? 0 : $urandom_range(0, 4));
    q.bx = rand_component(mode < 6 ? 0 : $urandom_range(0, 4));
    q.by = rand_component(mode < 6 ? 0 : $urandom_range(0, 4));
    q.bz = rand_component(mode < 6 ? 0 : $urandom_range(0, 4));
    q.bw = rand_component(mode < 6 ? 0 : $urandom_range(0, 4));
    return q;
  endfunction

  // Operand driver: changes inputs on the falling edge, holds until taken.
  always @(negedge clk) begin
    if (rst) begin
      op_ch.valid <= 1'b0;
    end else if (!op_ch.valid || op_taken) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        op_ch.valid <= 1'b0;
      end else if (pair_queue.size() == 0) begin
        op_ch.valid <= 1'b0;
      end else if (pair_queue.size() > QUIET_TAIL && $urandom_range(0, 99) < idle_odds) begin
        send_gap <= $urandom_range(0, 18);
        op_ch.valid <= 1'b0;
      end else begin
        qpair_t q;
        q = pair_queue.pop_front();
        op_ch.valid    <= 1'b1;
        op_ch.first_x  <= q.ax;
        op_ch.first_y  <= q.ay;
        op_ch.first_z  <= q.az;
        op_ch.first_w  <= q.aw;
        op_ch.second_x <= q.bx;
        op_ch.second_y <= q.by;
        op_ch.second_z <= q.bz;
        op_ch.second_w <= q.bw;
        if ($urandom_range(0, 49) == 0) idle_odds <= $urandom_range(0, 1) ? 0 : 12;
      end
    end
  end

  // Result ready: random stall bursts, none near the end.
  always @(negedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else if (stall_gap > 0) begin
      stall_gap <= stall_gap - 1;
      res_ch.ready <= 1'b0;
    end else if (pair_queue.size() > QUIET_TAIL && $urandom_range(0, 99) < idle_odds) begin
      stall_gap <= $urandom_range(0, 18);
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= 1'b1;
    end
  end

  // Record accepted operand beats and predict their results.
  always @(posedge clk) begin
    op_taken <= 1'b0;
    if (!rst && op_ch.valid && op_ch.ready) begin
      op_taken <= 1'b1;
      unit_expected.push_back(hamilton_unit({op_ch.first_x, op_ch.first_y, op_ch.first_z,
        op_ch.first_w, op_ch.second_x, op_ch.second_y, op_ch.second_z, op_ch.second_w}));
    end
  end

  // Result monitor: compare each beat with the oldest prediction.
  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (unit_expected.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat x=%0d y=%0d z=%0d w=%0d zero=%0b", $time,
          res_ch.out_x, res_ch.out_y, res_ch.out_z, res_ch.out_w, res_ch.zero_norm);
      end else begin
        unit_q_t e;
        e = unit_expected.pop_front();
        if (res_ch.out_x !== e.x) begin
          errors++;
          $display("%0t: out_x expected %0d actual %0d", $time, e.x, res_ch.out_x);
        end
        if (res_ch.out_y !== e.y) begin
          errors++;
          $display("%0t: out_y expected %0d actual %0d", $time, e.y, res_ch.out_y);
        end
        if (res_ch.out_z !== e.z) begin
          errors++;
          $display("%0t: out_z expected %0d actual %0d", $time, e.z, res_ch.out_z);
        end
        if (res_ch.out_w !== e.w) begin
          errors++;
          $display("%0t: out_w expected %0d actual %0d", $time, e.w, res_ch.out_w);
        end
        if (res_ch.zero_norm !== e.zero) begin
          errors++;
          $display("%0t: zero_norm expected %0b actual %0b", $time, e.zero, res_ch.zero_norm);
        end
      end
    end
  end

  // Watchdog on cycles with no beat on either channel.
  always @(posedge clk) begin
    if ((op_ch.valid && op_ch.ready) || (res_ch.valid && res_ch.ready) || stim_done) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_quaternion_product_normalized_unit NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic signed [W-1:0] vmax, vmin, one;
    vmax = {1'b0, {(W-1){1'b1}}};
    vmin = {1'b1, {(W-1){1'b0}}};
    one = W'(1 << F);
    op_ch.valid = 1'b0;
    op_ch.first_x = '0;
    op_ch.first_y = '0;
    op_ch.first_z = '0;
    op_ch.first_w = '0;
    op_ch.second_x = '0;
    op_ch.second_y = '0;
    op_ch.second_z = '0;
    op_ch.second_w = '0;
    res_ch.ready = 1'b0;

    // Directed: zero product, identities, full-scale extremes, basis units.
    pair_queue.push_back('0);
    pair_queue.push_back({vmax, vmin, one, vmax, W'(0), W'(0), W'(0), W'(0)});
    pair_queue.push_back({W'(0), W'(0), W'(0), one, W'(0), W'(0), W'(0), one});
    pair_queue.push_back({vmin, vmin, vmin, vmin, vmin, vmin, vmin, vmin});
    pair_queue.push_back({vmax, vmax, vmax, vmax, vmax, vmax, vmax, vmax});
    pair_queue.push_back({vmin, vmax, vmin, vmax, vmax, vmin, vmax, vmin});
    pair_queue.push_back({one, W'(0), W'(0), W'(0), one, W'(0), W'(0), W'(0)});
    pair_queue.push_back({W'(0), one, W'(0), W'(0), W'(0), W'(0), one, W'(0)});
    pair_queue.push_back({W'(0), W'(0), W'(1), W'(0), W'(0), W'(0), W'(0), W'(1)});
    pair_queue.push_back({W'(1), W'(1), W'(0), W'(0), W'(1), W'(0), W'(0), W'(0)});
    pair_queue.push_back({W'(-1), W'(0), W'(0), W'(0), W'(0), W'(0), W'(0), W'(1)});
    pair_queue.push_back({W'(1), W'(2), W'(3), W'(4), W'(-4), W'(3), W'(-2), W'(1)});
    pair_queue.push_back({vmin, W'(0), W'(0), W'(0), vmin, W'(0), W'(0), W'(0)});
    pair_queue.push_back({W'(0), W'(0), W'(0), vmin, W'(0), W'(0), W'(0), vmax});
    pair_queue.push_back({W'(-1), W'(-1), W'(-1), W'(-1), W'(1), W'(1), W'(1), W'(1)});
    for (int i = 0; i < RANDOM_PAIRS; i++) pair_queue.push_back(rand_pair());

    repeat (2) @(negedge clk);
    rst = 1'b0;

    wait (pair_queue.size() == 0 && !op_ch.valid && unit_expected.size() == 0);
    stim_done = 1'b1;
    repeat (2 * (W + 6)) @(posedge clk);
    if (errors == 0) begin
      $display("tb_quaternion_product_normalized_unit OK");
    end else begin
      $display("tb_quaternion_product_normalized_unit NOT OK");
    end
    $finish;
  end

endmodule
